// File: sv/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants of the C subset lexer: item and token layouts,
// token kind codes, keyword spellings and the bundle type of the token queue.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int ValueBits  = 32;
  localparam int PosBits    = 16;
  localparam int QueueDepth = 4;

  localparam logic [3:0] KindNumber = 4'd0;
  localparam logic [3:0] KindReturn = 4'd1;
  localparam logic [3:0] KindIf     = 4'd2;
  localparam logic [3:0] KindElse   = 4'd3;
  localparam logic [3:0] KindWhile  = 4'd4;
  localparam logic [3:0] KindFor    = 4'd5;
  localparam logic [3:0] KindIdent  = 4'd6;
  localparam logic [3:0] KindPunct  = 4'd7;
  localparam logic [3:0] KindEnd    = 4'd8;
  localparam logic [3:0] KindError  = 4'd9;

  localparam logic [47:0] KwReturn = "return";
  localparam logic [47:0] KwIf     = "if";
  localparam logic [47:0] KwElse   = "else";
  localparam logic [47:0] KwWhile  = "while";
  localparam logic [47:0] KwFor    = "for";

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]           token_kind;
    logic [PosBits-1:0]   token_start;
    logic [PosBits-1:0]   token_length;
    logic [ValueBits-1:0] number_value;
    logic [7:0]           first_char;
    logic [7:0]           second_char;
    logic                 last_of_run;
  } token_t;

  // Tokens caused by one character: one or two.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_port_t;

endpackage

// File: sv/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small C subset, one source character per transaction.
// ----------------------------------------------------------------------------
// Input channel: a character transaction is taken on a clock edge with push
// high and full low. Set end_of_text to flush the pending token and get an
// end token; the lexer then starts over at position zero.
// Output channel: while empty is low, token_o holds the oldest token; it is
// taken on an edge with pop high. last_of_run marks the final token that a
// character caused (zero, one or two tokens per character).
// Throughput: one character per cycle while full is low and one token per
// cycle while the receiver pops; a character that yields two tokens takes
// the output once per token. The lexer writes the queue on the edge that
// takes the character; its first token then moves from the queue into the
// output register once that register is empty or popped, and shows on token_o.
// When the receiver stalls, the token queue (QUEUE_DEPTH bundles) absorbs
// characters until it fills and full rises.
// Reset clears the lexer state, the queue and the valid flag of the output
// register; the block can take characters as soon as reset is released.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
  parameter int QUEUE_DEPTH = csl_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  csl_pkg::in_item_t in_item_i,
  output logic              empty,
  input  logic              pop,
  output csl_pkg::token_t   token_o
);

  csl_pkg::q_port_t wr, rd;
  logic             accept, deq;

  assign accept = push & ~full;

  csl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_item_i),
    .wr_o     (wr)
  );

  csl_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .deq_i  (deq),
    .rd_o   (rd),
    .full_o (full)
  );

  csl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .deq_o   (deq),
    .pop_i   (pop),
    .empty_o (empty),
    .tok_o   (token_o)
  );

`ifndef SYNTH
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_o.token_kind == csl_pkg::KindEnd) |-> token_o.last_of_run)
    else $error("end token not marked as last of its run");

  a_value_only_number : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_o.token_kind != csl_pkg::KindNumber) |-> token_o.number_value == '0)
    else $error("nonzero value on a token that is not a number");

  a_second_char_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_o.second_char != 8'h00) |->
      (token_o.token_kind == csl_pkg::KindPunct && token_o.token_length == 16'd2))
    else $error("second character on a token that is not a two-character operator");
`endif

endmodule

// File: sv/csl_front.sv
// ----------------------------------------------------------------------------
// csl_front
// Lexer state machine: takes one character per cycle while accept_i is high
// and forms the token bundle that the character completes.
// ----------------------------------------------------------------------------
module csl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  csl_pkg::in_item_t  in_i,
  output csl_pkg::q_port_t   wr_o
);

  localparam int VB = csl_pkg::ValueBits;
  localparam int PB = csl_pkg::PosBits;

  localparam logic [7:0] CharEq   = 8'h3D;
  localparam logic [7:0] CharBang = 8'h21;
  localparam logic [7:0] CharLt   = 8'h3C;
  localparam logic [7:0] CharGt   = 8'h3E;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeNum,
    ModeWord,
    ModeOper
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [PB-1:0]   pos_q, pos_d;
  logic [PB-1:0]   start_q, start_d;
  logic [PB-1:0]   len_q, len_d;
  logic [VB-1:0]   acc_q, acc_d;
  logic [47:0]     prefix_q, prefix_d;
  logic [7:0]      op_q, op_d;
  logic            err_q, err_d;

  logic [7:0]      c;
  logic            is_space, is_digit, is_alpha, is_punct, is_op;
  logic [3:0]      digit;
  logic [VB+3:0]   acc_wide;
  logic [VB-1:0]   acc_next;
  logic [PB-1:0]   len_grow;
  logic [3:0]      word_kind;
  logic            flush_v;
  csl_pkg::token_t flush_tok, new_tok, t0, t1;
  logic            emit_flush, emit_new;

  assign c        = in_i.char_code;
  assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                    (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  assign is_op    = (c == CharEq) || (c == CharBang) || (c == CharLt) || (c == CharGt);
  assign digit    = c[3:0];

  // value * 10 + digit; saturate when the result no longer fits.
  assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VB + 4)'(digit);
  assign acc_next = (acc_wide[VB+3:VB] != 4'b0) ? '1 : acc_wide[VB-1:0];
  assign len_grow = (len_q == '1) ? len_q : len_q + PB'(1);

  always_comb begin
    priority if (len_q == PB'(6) && prefix_q == csl_pkg::KwReturn) word_kind = csl_pkg::KindReturn;
    else if (len_q == PB'(2) && prefix_q == csl_pkg::KwIf)         word_kind = csl_pkg::KindIf;
    else if (len_q == PB'(4) && prefix_q == csl_pkg::KwElse)       word_kind = csl_pkg::KindElse;
    else if (len_q == PB'(5) && prefix_q == csl_pkg::KwWhile)      word_kind = csl_pkg::KindWhile;
    else if (len_q == PB'(3) && prefix_q == csl_pkg::KwFor)        word_kind = csl_pkg::KindFor;
    else                                                           word_kind = csl_pkg::KindIdent;
  end

  // Token that the pending run turns into when something ends it.
  always_comb begin
    flush_tok             = '0;
    flush_tok.token_start = start_q;
    flush_tok.token_length = len_q;
    flush_v               = 1'b1;
    unique case (mode_q)
      ModeNum: begin
        flush_tok.token_kind   = csl_pkg::KindNumber;
        flush_tok.number_value = acc_q;
      end
      ModeWord: begin
        flush_tok.token_kind = word_kind;
      end
      ModeOper: begin
        flush_tok.token_kind   = csl_pkg::KindPunct;
        flush_tok.token_length = PB'(1);
        flush_tok.first_char   = op_q;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    start_d    = start_q;
    len_d      = len_q;
    acc_d      = acc_q;
    prefix_d   = prefix_q;
    op_d       = op_q;
    err_d      = err_q;
    emit_flush = 1'b0;
    emit_new   = 1'b0;
    new_tok    = '0;
    if (accept_i) begin
      if (in_i.end_of_text) begin
        emit_flush          = ~err_q & flush_v;
        emit_new            = 1'b1;
        new_tok.token_kind  = csl_pkg::KindEnd;
        new_tok.token_start = pos_q;
        mode_d              = ModeIdle;
        pos_d               = '0;
        start_d             = '0;
        len_d               = '0;
        acc_d               = '0;
        prefix_d            = '0;
        op_d                = '0;
        err_d               = 1'b0;
      end else begin
        pos_d = pos_q + PB'(1);
        if (!err_q) begin
          if (mode_q == ModeOper && c == CharEq) begin
            emit_new             = 1'b1;
            new_tok.token_kind   = csl_pkg::KindPunct;
            new_tok.token_start  = start_q;
            new_tok.token_length = PB'(2);
            new_tok.first_char   = op_q;
            new_tok.second_char  = c;
            mode_d               = ModeIdle;
          end else if (mode_q == ModeNum && is_digit) begin
            acc_d = acc_next;
            len_d = len_grow;
          end else if (mode_q == ModeWord && (is_alpha || is_digit)) begin
            if (len_q < PB'(6)) begin
              prefix_d = {prefix_q[39:0], c};
            end
            len_d = len_grow;
          end else begin
            emit_flush = flush_v;
            mode_d     = ModeIdle;
            priority if (is_digit) begin
              mode_d  = ModeNum;
              start_d = pos_q;
              len_d   = PB'(1);
              acc_d   = VB'(digit);
            end else if (is_alpha) begin
              mode_d   = ModeWord;
              start_d  = pos_q;
              len_d    = PB'(1);
              prefix_d = 48'(c);
            end else if (is_op) begin
              mode_d  = ModeOper;
              start_d = pos_q;
              len_d   = PB'(1);
              op_d    = c;
            end else if (is_punct) begin
              emit_new             = 1'b1;
              new_tok.token_kind   = csl_pkg::KindPunct;
              new_tok.token_start  = pos_q;
              new_tok.token_length = PB'(1);
              new_tok.first_char   = c;
            end else if (!is_space) begin
              emit_new             = 1'b1;
              new_tok.token_kind   = csl_pkg::KindError;
              new_tok.token_start  = pos_q;
              new_tok.token_length = PB'(1);
              err_d                = 1'b1;
            end else begin
              // Whitespace only ends the pending run.
              mode_d = ModeIdle;
            end
          end
        end
      end
    end
  end

  always_comb begin
    t0 = emit_flush ? flush_tok : new_tok;
    t1 = new_tok;
    t0.last_of_run = ~(emit_flush & emit_new);
    t1.last_of_run = 1'b1;
  end

  assign wr_o.valid     = accept_i & (emit_flush | emit_new);
  assign wr_o.data.two  = emit_flush & emit_new;
  assign wr_o.data.tok0 = t0;
  assign wr_o.data.tok1 = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      acc_q    <= '0;
      prefix_q <= '0;
      op_q     <= '0;
      err_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
      prefix_q <= prefix_d;
      op_q     <= op_d;
      err_q    <= err_d;
    end
  end

endmodule

// File: sv/csl_fifo.sv
// ----------------------------------------------------------------------------
// csl_fifo
// Short queue of token bundles between the lexer front and the token output.
// ----------------------------------------------------------------------------
module csl_fifo #(
  parameter int Depth = csl_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csl_pkg::q_port_t wr_i,
  input  logic             deq_i,
  output csl_pkg::q_port_t rd_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  csl_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign do_wr      = wr_i.valid & ~full_o;
  assign do_rd      = deq_i & (cnt_q != '0);
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.data  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/csl_back.sv
// ----------------------------------------------------------------------------
// csl_back
// Token output stage: splits each queued bundle into single tokens and holds
// the oldest one in an output register until it is taken.
// ----------------------------------------------------------------------------
module csl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csl_pkg::q_port_t rd_i,
  output logic             deq_o,
  input  logic             pop_i,
  output logic             empty_o,
  output csl_pkg::token_t  tok_o
);

  logic            out_valid_q, out_valid_d;
  logic            sel_q, sel_d;
  csl_pkg::token_t out_q, out_d;
  logic            load;

  // The register can take a new token when it is empty or its token leaves now.
  assign load    = ~out_valid_q | pop_i;
  assign empty_o = ~out_valid_q;
  assign tok_o   = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sel_d       = sel_q;
    deq_o       = 1'b0;
    if (load) begin
      out_valid_d = rd_i.valid;
      if (rd_i.valid) begin
        out_d = sel_q ? rd_i.data.tok1 : rd_i.data.tok0;
        if (rd_i.data.two && !sel_q) begin
          sel_d = 1'b1;
        end else begin
          sel_d = 1'b0;
          deq_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

endmodule
